>>> rtl/core/fir_fc_pkg.sv
package fir_fc_pkg;

    // filter dimensions
    localparam int MAX_ORDER  = 64;
    localparam int ORDER_W    = 7;
    localparam int HIST_AW    = 6;
    localparam int COEF_DEPTH = MAX_ORDER + 1;
    localparam int COEF_AW    = 7;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 38;
    localparam int FRAC_BITS  = 15;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd16;
    localparam logic [ORDER_W-1:0] ORDER_MAX   = 7'd64;

    // request opcodes, the fourth code is unused
    typedef enum logic [1:0] {
        ACT_FILTER = 2'd0,
        ACT_COEFF  = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

endpackage

>>> rtl/core/fir_fc_if.sv
interface fir_fc_in_if
    import fir_fc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] sample_in;
    logic [ORDER_W-1:0]       coeff_index;
    logic signed [DATA_W-1:0] coeff_value;

    modport source (output valid, action, sample_in, coeff_index, coeff_value,
                    input ready);
    modport sink   (input valid, action, sample_in, coeff_index, coeff_value,
                    output ready);
endinterface

interface fir_fc_out_if
    import fir_fc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered_out;
    logic                     saturated;

    modport source (output valid, filtered_out, saturated, input ready);
    modport sink   (input valid, filtered_out, saturated, output ready);
endinterface

interface fir_fc_cfg_if
    import fir_fc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ORDER_W-1:0] filter_order;

    modport source (output valid, filter_order, input ready);
    modport sink   (input valid, filter_order, output ready);
endinterface

>>> rtl/core/fir_fc_ram.sv
module fir_fc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/fir_filter_circular_core.sv
// fir_filter_circular_core: direct-form fir filter over a circular sample history
//
// item (sink): one request per handshake; action selects filter a sample, write one
//   coefficient slot (0..64, higher slots are dropped) or clear history and position.
// result (source): one filtered sample with a clip flag per filter request only.
// cfg (sink): writes filter_order, always ready; change it only while the block idles.
//
// a filter request runs from acceptance through the taps to the result register
// (order taken as 1..64): one shared 16x16 multiplier and accumulator walk the taps
// one per cycle behind the registered history and coefficient memory reads.
// item.ready is low while a sample is in work and returns as the result is posted,
// so a new request waits until the last sample is through; coefficient writes and
// clears finish in the acceptance cycle.
// a finished result waits in the output register while result.ready is low; the next
// request is still accepted, but the following sample holds in its last step until
// the register frees up.
// reset: order 16, history, position and all coefficients read as zero (valid bits
// cleared in the reset cycle, no sweep).
module fir_filter_circular_core
    import fir_fc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    fir_fc_in_if.sink    item,
    fir_fc_out_if.source result,
    fir_fc_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [ORDER_W-1:0]       order_reg;
    logic [ORDER_W-1:0]       ord_reg;
    logic [HIST_AW-1:0]       wpos_reg;
    logic [HIST_AW-1:0]       pos_reg;
    logic [HIST_AW-1:0]       hidx_reg;
    logic [COEF_AW-1:0]       tap_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [MAX_ORDER-1:0]     hist_valid_reg;
    logic [COEF_DEPTH-1:0]    coef_valid_reg;
    logic                     s1_vld_reg;
    logic                     s1_last_reg;
    logic                     s1_hval_reg;
    logic                     s1_cval_reg;
    logic                     s2_vld_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_sat_reg;

    logic [ORDER_W-1:0]       eff_order;
    logic [HIST_AW-1:0]       start_pos;
    logic [HIST_AW-1:0]       hidx_next;
    logic [HIST_AW-1:0]       wpos_next;
    logic                     item_acc;
    logic                     slot_free;
    logic                     coef_we;
    logic                     hist_we;
    logic [DATA_W-1:0]        hist_rdata;
    logic [DATA_W-1:0]        coef_rdata;
    logic signed [DATA_W-1:0] hist_op;
    logic signed [DATA_W-1:0] coef_op;
    logic signed [ACC_W-FRAC_BITS-1:0] acc_shift;
    logic                     clip;
    logic signed [DATA_W-1:0] y_sat;

    // handshakes
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_acc   = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.filtered_out = out_data_reg;
    assign result.saturated    = out_sat_reg;

    // order clamped to 1..64, stale position falls back to 0
    always_comb
    begin
        priority if (order_reg == '0)
            eff_order = ORDER_W'(1);
        else if (order_reg > ORDER_MAX)
            eff_order = ORDER_MAX;
        else
            eff_order = order_reg;
        start_pos = ({1'b0, wpos_reg} >= eff_order) ? '0 : wpos_reg;
    end

    // circular index steps with wrap at the order
    assign hidx_next = ({1'b0, hidx_reg} + ORDER_W'(1) == ord_reg) ? '0
                                                                  : hidx_reg + HIST_AW'(1);
    assign wpos_next = ({1'b0, pos_reg} + ORDER_W'(1) == ord_reg) ? '0
                                                                 : pos_reg + HIST_AW'(1);

    // memory write strobes
    assign coef_we = item_acc && (item.action == ACT_COEFF) && (item.coeff_index <= ORDER_MAX);
    assign hist_we = (state_reg == ST_FINISH) && slot_free;

    fir_fc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ORDER)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pos_reg),
        .wdata (x_reg),
        .raddr (hidx_reg),
        .rdata (hist_rdata)
    );

    fir_fc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (item.coeff_index),
        .wdata (item.coeff_value),
        .raddr (tap_reg),
        .rdata (coef_rdata)
    );

    // multiplier operands, unwritten entries read as zero, last tap takes the new sample
    always_comb
    begin
        coef_op = s1_cval_reg ? $signed(coef_rdata) : '0;
        if (s1_last_reg)
            hist_op = x_reg;
        else
            hist_op = s1_hval_reg ? $signed(hist_rdata) : '0;
    end

    // floor shift and clip to 16 bits
    always_comb
    begin
        acc_shift = acc_reg[ACC_W-1:FRAC_BITS];
        clip      = (acc_shift > $signed((ACC_W-FRAC_BITS)'(32767)))
                 || (acc_shift < -$signed((ACC_W-FRAC_BITS)'(32768)));
        if (!clip)
            y_sat = acc_shift[DATA_W-1:0];
        else if (acc_shift[ACC_W-FRAC_BITS-1])
            y_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // sequencer, tap pipeline and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            order_reg      <= ORDER_RESET;
            ord_reg        <= ORDER_W'(1);
            wpos_reg       <= '0;
            pos_reg        <= '0;
            hidx_reg       <= '0;
            tap_reg        <= '0;
            x_reg          <= '0;
            hist_valid_reg <= '0;
            coef_valid_reg <= '0;
            s1_vld_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_hval_reg    <= 1'b0;
            s1_cval_reg    <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s2_last_reg    <= 1'b0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            // register write
            if (cfg.valid && cfg.ready)
            begin
                order_reg <= cfg.filter_order;
            end

            // result register drains on the receiver side
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // read stage: flags follow the registered memory reads
            s1_vld_reg  <= (state_reg == ST_CALC);
            s1_last_reg <= (state_reg == ST_CALC) && ({1'b0, tap_reg} == {1'b0, ord_reg});
            s1_hval_reg <= hist_valid_reg[hidx_reg];
            s1_cval_reg <= coef_valid_reg[tap_reg];

            // multiply stage
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_vld_reg && s1_last_reg;
            prod_reg    <= hist_op * coef_op;

            // accumulate stage
            if (s2_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc)
                    begin
                        unique case (item.action)
                            ACT_FILTER:
                            begin
                                ord_reg   <= eff_order;
                                pos_reg   <= start_pos;
                                hidx_reg  <= start_pos;
                                tap_reg   <= '0;
                                x_reg     <= item.sample_in;
                                acc_reg   <= '0;
                                state_reg <= ST_CALC;
                            end
                            ACT_COEFF:
                            begin
                                if (item.coeff_index <= ORDER_MAX)
                                begin
                                    coef_valid_reg[item.coeff_index] <= 1'b1;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                hist_valid_reg <= '0;
                                wpos_reg       <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_CALC:
                begin
                    // one tap address pair per cycle, the last one reads coefficient order
                    if (tap_reg == ord_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        tap_reg  <= tap_reg + COEF_AW'(1);
                        hidx_reg <= hidx_next;
                    end
                end
                ST_DRAIN:
                begin
                    if (s2_last_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // store the sample, advance the position and post the result
                    if (slot_free)
                    begin
                        hist_valid_reg[pos_reg] <= 1'b1;
                        wpos_reg      <= wpos_next;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= y_sat;
                        out_sat_reg   <= clip;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> verif/tb_top.sv
module tb_top
    import fir_fc_pkg::*;
;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         PHASE_ITEMS = 210;
    localparam int         SETTLE_CYC  = MAX_ORDER + 16;

    typedef struct {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] sample;
        logic [ORDER_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
    } fir_req_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } filt_result_t;

    typedef struct {
        fir_req_t     req;
        bit           typed;
        filt_result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    fir_fc_in_if  item_if ();
    fir_fc_out_if res_if ();
    fir_fc_cfg_if cfg_if ();

    fir_filter_circular_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // filter state mirror
    logic [ORDER_W-1:0]       order_reg;
    logic signed [DATA_W-1:0] hist_mem [0:MAX_ORDER-1];
    logic signed [DATA_W-1:0] coef_mem [0:COEF_DEPTH-1];
    int unsigned              wr_pos;

    filt_result_t pending_outputs [$];
    int error_count;
    int samples_sent;
    int results_checked;
    int src_idle_pct;
    int sink_stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("fir_filter_circular_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // one request through the filter mirror
    function automatic void filter_step(input fir_req_t r, output bit has_out,
                                        output filt_result_t res);
        int unsigned ord;
        int unsigned pos;
        int unsigned n;
        longint      acc;
        longint      y;
        has_out   = 1'b0;
        res.value = '0;
        res.sat   = 1'b0;
        case (r.action)
            ACT_COEFF:
            begin
                // slots above the last tap are dropped
                if (r.index <= MAX_ORDER)
                    coef_mem[r.index] = r.value;
            end
            ACT_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
                wr_pos = 0;
            end
            ACT_FILTER:
            begin
                // order 0 runs as 1, anything above the maximum runs as the maximum
                ord = order_reg;
                if (ord == 0)
                    ord = 1;
                if (ord > MAX_ORDER)
                    ord = MAX_ORDER;
                // position left over from a larger order restarts at 0
                pos = (wr_pos >= ord) ? 0 : wr_pos;
                acc = 0;
                for (int i = 0; i < ord; i++)
                begin
                    n = pos + i;
                    if (n >= ord)
                        n -= ord;
                    acc += longint'(hist_mem[n]) * longint'(coef_mem[i]);
                end
                acc += longint'(coef_mem[ord]) * longint'(r.sample);
                hist_mem[pos] = r.sample;
                pos++;
                if (pos >= ord)
                    pos = 0;
                wr_pos = pos;
                // floor shift, then clip to 16 bits
                y = acc >>> FRAC_BITS;
                if (y > 32767)
                begin
                    y       = 32767;
                    res.sat = 1'b1;
                end
                else if (y < -32768)
                begin
                    y       = -32768;
                    res.sat = 1'b1;
                end
                res.value = y[DATA_W-1:0];
                has_out   = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic dir_row_t row(input logic [1:0] act, input int smp, input int idx,
                                     input int val, input bit typed = 1'b0,
                                     input int want = 0, input bit want_sat = 1'b0);
        dir_row_t d;
        d.req.action = act;
        d.req.sample = smp[DATA_W-1:0];
        d.req.index  = idx[ORDER_W-1:0];
        d.req.value  = val[DATA_W-1:0];
        d.typed      = typed;
        d.want.value = want[DATA_W-1:0];
        d.want.sat   = want_sat;
        return d;
    endfunction

    function automatic fir_req_t random_request();
        fir_req_t r;
        int       pick;
        pick     = $urandom_range(0, 99);
        r.sample = DATA_W'($urandom);
        r.index  = ORDER_W'($urandom);
        r.value  = DATA_W'($urandom);
        if (pick < 62)
        begin
            r.action = ACT_FILTER;
            case ($urandom_range(0, 9))
                0: r.sample = 16'h7FFF;
                1: r.sample = 16'h8000;
                2: r.sample = '0;
                default: ;
            endcase
        end
        else if (pick < 90)
        begin
            r.action = ACT_COEFF;
            if ($urandom_range(0, 9) == 0)
                r.index = ORDER_W'($urandom_range(MAX_ORDER + 1, 127));
            else
                r.index = ORDER_W'($urandom_range(0, MAX_ORDER));
            // mostly scaled taps so that outputs are not always clipped
            case ($urandom_range(0, 9))
                0: r.value = 16'h7FFF;
                1: r.value = 16'h8000;
                default: r.value = r.value >>> $urandom_range(0, 7);
            endcase
        end
        else if (pick < 95)
            r.action = ACT_CLEAR;
        else
            r.action = ACT_UNUSED;
        return r;
    endfunction

    // drive one request and record what it should produce
    task automatic send_request(input fir_req_t r, input bit typed, input filt_result_t want);
        bit           has_out;
        filt_result_t pred;
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= r.action;
        item_if.sample_in   <= r.sample;
        item_if.coeff_index <= r.index;
        item_if.coeff_value <= r.value;
        do
            @(posedge clk);
        while (!(item_if.valid === 1'b1 && item_if.ready === 1'b1));
        filter_step(r, has_out, pred);
        if (has_out)
        begin
            samples_sent++;
            pending_outputs.push_back(typed ? want : pred);
        end
    endtask

    // drop the request line, drain results, then let the datapath settle
    task automatic wait_quiet();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] ord);
        @(negedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.filter_order <= ord;
        do
            @(posedge clk);
        while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
        order_reg = ord;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        res_if.ready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        filt_result_t exp_r;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result %0d sat %0b",
                                          res_if.filtered_out, res_if.saturated));
            else
            begin
                exp_r = pending_outputs.pop_front();
                results_checked++;
                if (res_if.filtered_out !== exp_r.value)
                    report_mismatch($sformatf("filtered_out %0d, expected %0d",
                                              res_if.filtered_out, exp_r.value));
                if (res_if.saturated !== exp_r.sat)
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              res_if.saturated, exp_r.sat));
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t           dir_tbl [$];
        logic [ORDER_W-1:0] order_plan [$];
        fir_req_t           r;
        filt_result_t       none;
        int                 counted;
        item_if.valid       = 1'b0;
        item_if.action      = ACT_FILTER;
        item_if.sample_in   = '0;
        item_if.coeff_index = '0;
        item_if.coeff_value = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.filter_order = ORDER_RESET;
        res_if.ready        = 1'b1;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        error_count         = 0;
        samples_sent        = 0;
        results_checked     = 0;
        none.value          = '0;
        none.sat            = 1'b0;

        // mirror reset state
        order_reg = ORDER_RESET;
        wr_pos    = 0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        foreach (coef_mem[i])
            coef_mem[i] = '0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state, extremes, out of range slots, unused code, clear
        dir_tbl.push_back(row(ACT_FILTER, 0, 0, 0, 1, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, 32767, 0, 0, 1, 0, 0));
        dir_tbl.push_back(row(ACT_COEFF, 0, 16, -32768));
        dir_tbl.push_back(row(ACT_FILTER, -32768, 0, 0, 1, 32767, 1));
        dir_tbl.push_back(row(ACT_COEFF, 0, 16, 32767));
        dir_tbl.push_back(row(ACT_FILTER, 32767, 0, 0, 1, 32766, 0));
        dir_tbl.push_back(row(ACT_FILTER, -32768, 0, 0, 1, -32767, 0));
        dir_tbl.push_back(row(ACT_COEFF, 0, 64, 32767));
        dir_tbl.push_back(row(ACT_COEFF, 0, 65, 1234));
        dir_tbl.push_back(row(ACT_COEFF, -1, 127, -1));
        dir_tbl.push_back(row(ACT_COEFF, 0, 0, -32768));
        dir_tbl.push_back(row(ACT_COEFF, 0, 15, -32768));
        dir_tbl.push_back(row(ACT_FILTER, 32767, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, -32768, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, -32768, 127, -1));
        dir_tbl.push_back(row(ACT_UNUSED, -1, 127, -1));
        dir_tbl.push_back(row(ACT_CLEAR, -1, 127, -1));
        dir_tbl.push_back(row(ACT_FILTER, 0, 0, 0, 1, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, 32767, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, 32767, 0, 0));
        dir_tbl.push_back(row(ACT_COEFF, 0, 1, 16384));
        dir_tbl.push_back(row(ACT_FILTER, -32768, 0, 0));
        dir_tbl.push_back(row(ACT_FILTER, 12345, 0, 0));
        foreach (dir_tbl[i])
            send_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
        wait_quiet();

        // random phases; lowering the order after a long one leaves a stale position
        order_plan = '{7'd1, 7'd64, 7'd5, 7'd0, 7'd127, 7'd9, 7'd65, 7'd3};
        order_plan.push_back(ORDER_W'($urandom_range(0, 127)));
        foreach (order_plan[p])
        begin
            write_order(order_plan[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = random_request();
                send_request(r, 1'b0, none);
                if (r.action != ACT_UNUSED)
                    counted++;
            end
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            wait_quiet();
        end

        if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));

        $display("summary: %0d samples filtered, %0d results checked", samples_sent,
                 results_checked);
        $display("summary: %0d order settings, idle and stall mixes, %0d mismatches",
                 order_plan.size() + 1, error_count);
        if (error_count == 0)
            $display("fir_filter_circular_core verification clean");
        else
            $display("fir_filter_circular_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/fir_fc_pkg.sv
rtl/core/fir_fc_if.sv
rtl/core/fir_fc_ram.sv
rtl/core/fir_filter_circular_core.sv
verif/tb_top.sv
